// File: hw/rtl/tesp_pkg.sv
// ----------------------------------------------------------------------------
// Terminal escape sequence parser package
// Shared types, default sizes and character codes for the parser modules.
// ----------------------------------------------------------------------------
package tesp_pkg;

  localparam int unsigned ArgSlotsDef    = 16;
  localparam int unsigned CsiBufBytesDef = 512;
  localparam int unsigned StringLimitDef = 16384;

  // Bit positions in the escape flag register.
  localparam int unsigned FlStart  = 0;
  localparam int unsigned FlCsi    = 1;
  localparam int unsigned FlStr    = 2;
  localparam int unsigned FlAlt    = 3;
  localparam int unsigned FlStrEnd = 4;
  localparam int unsigned FlTest   = 5;
  localparam int unsigned FlUtf8   = 6;
  localparam int unsigned FlDcs    = 7;

  // Character codes.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChEnq   = 8'h05;
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChHt    = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSo    = 8'h0E;
  localparam logic [7:0] ChSi    = 8'h0F;
  localparam logic [7:0] ChXon   = 8'h11;
  localparam logic [7:0] ChXoff  = 8'h13;
  localparam logic [7:0] ChCan   = 8'h18;
  localparam logic [7:0] ChSub   = 8'h1A;
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ChDcs   = 8'h90;
  localparam logic [7:0] ChOsc   = 8'h9D;
  localparam logic [7:0] ChPm    = 8'h9E;
  localparam logic [7:0] ChApc   = 8'h9F;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChLPar  = 8'h28;
  localparam logic [7:0] ChRPar  = 8'h29;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChFinLo = 8'h40;
  localparam logic [7:0] ChUpP   = 8'h50;
  localparam logic [7:0] ChLBrk  = 8'h5B;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChRBrk  = 8'h5D;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChLowK  = 8'h6B;
  localparam logic [7:0] ChLowQ  = 8'h71;
  localparam logic [7:0] ChFinHi = 8'h7E;

  typedef enum logic [3:0] {
    EV_PRINT       = 4'd0,
    EV_CONTROL     = 4'd1,
    EV_ESC_FINAL   = 4'd2,
    EV_CSI_ARG     = 4'd3,
    EV_CSI_FINAL   = 4'd4,
    EV_CHARSET     = 4'd5,
    EV_UTF8_SELECT = 4'd6,
    EV_DEC_TEST    = 4'd7,
    EV_STR_START   = 4'd8,
    EV_STR_BYTE    = 4'd9,
    EV_STR_DISPATCH = 4'd10,
    EV_STR_OVERFLOW = 4'd11
  } event_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PLOAD,
    S_PPRIV,
    S_PTOP,
    S_PDIG,
    S_PM0,
    S_PM1,
    S_PEMIT
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic par_init;
    logic par_priv;
    logic par_dig;
    logic par_m0;
    logic par_m1;
    logic emit_arg;
    logic emit_fin;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic start_parse;
    logic p_lt_len;
    logic byte_digit;
    logic byte_semi;
    logic narg_last;
    logic ei_lt_narg;
  } sts_t;

endpackage

// File: hw/rtl/tesp_ctrl.sv
// ----------------------------------------------------------------------------
// Parser controller
// Sequences item intake, classification and the CSI argument scan.
// ----------------------------------------------------------------------------
module tesp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tesp_pkg::sts_t   sts_i,
  output tesp_pkg::cmd_t   cmd_o
);

  tesp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tesp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tesp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = tesp_pkg::S_EXEC;
        end
      end
      tesp_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.start_parse ? tesp_pkg::S_PLOAD : tesp_pkg::S_IDLE;
        end
      end
      tesp_pkg::S_PLOAD: begin
        cmd_o.par_init = 1'b1;
        state_d        = tesp_pkg::S_PPRIV;
      end
      tesp_pkg::S_PPRIV: begin
        cmd_o.par_priv = 1'b1;
        state_d        = tesp_pkg::S_PTOP;
      end
      tesp_pkg::S_PTOP: begin
        state_d = sts_i.p_lt_len ? tesp_pkg::S_PDIG : tesp_pkg::S_PM0;
      end
      tesp_pkg::S_PDIG: begin
        cmd_o.par_dig = 1'b1;
        if (!sts_i.byte_digit) begin
          if (sts_i.byte_semi && !sts_i.narg_last) begin
            state_d = tesp_pkg::S_PTOP;
          end else begin
            state_d = tesp_pkg::S_PM0;
          end
        end
      end
      tesp_pkg::S_PM0: begin
        cmd_o.par_m0 = 1'b1;
        state_d      = tesp_pkg::S_PM1;
      end
      tesp_pkg::S_PM1: begin
        cmd_o.par_m1 = 1'b1;
        state_d      = tesp_pkg::S_PEMIT;
      end
      tesp_pkg::S_PEMIT: begin
        if (sts_i.out_free) begin
          if (sts_i.ei_lt_narg) begin
            cmd_o.emit_arg = 1'b1;
          end else begin
            cmd_o.emit_fin = 1'b1;
            state_d        = tesp_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = tesp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/tesp_dpath.sv
// ----------------------------------------------------------------------------
// Parser datapath
// Escape state, CSI byte buffer, argument scanner and output register.
// ----------------------------------------------------------------------------
module tesp_dpath #(
  parameter int unsigned ARG_SLOTS     = tesp_pkg::ArgSlotsDef,
  parameter int unsigned CSI_BUF_BYTES = tesp_pkg::CsiBufBytesDef,
  parameter int unsigned STRING_LIMIT  = tesp_pkg::StringLimitDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [20:0]           code_point_i,
  input  logic [2:0]            byte_count_i,
  input  tesp_pkg::cmd_t        cmd_i,
  output tesp_pkg::sts_t        sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            event_kind_o,
  output logic [20:0]           code_o,
  output logic [3:0]            arg_index_o,
  output logic signed [16:0]    arg_value_o,
  output logic                  private_mark_o,
  output logic [7:0]            second_mode_o,
  output logic [1:0]            charset_slot_o,
  output logic                  last_o
);

  localparam int unsigned LenW  = $clog2(CSI_BUF_BYTES + 1);
  localparam int unsigned AddrW = $clog2(CSI_BUF_BYTES);
  localparam int unsigned SlenW = $clog2(STRING_LIMIT);
  localparam int unsigned NargW = $clog2(ARG_SLOTS + 1);
  localparam int unsigned IdxW  = (ARG_SLOTS > 1) ? $clog2(ARG_SLOTS) : 1;

  // Item register.
  logic [20:0] cp_q;
  logic [2:0]  bc_q;

  // Escape state.
  logic [7:0]       flags_q, flags_d;
  logic             six_q, six_d;
  logic [LenW-1:0]  clen_q, clen_d;
  logic [SlenW-1:0] slen_q, slen_d;
  logic [7:0]       skind_q, skind_d;
  logic [1:0]       dslot_q, dslot_d;

  // CSI buffer.
  logic [7:0] mem [CSI_BUF_BYTES];
  logic [7:0] rdata_q;

  // Argument scanner.
  logic [LenW-1:0]  p_q, p_d;
  logic             priv_q, priv_d;
  logic [15:0]      acc_q, acc_d;
  logic             over_q, over_d;
  logic [NargW-1:0] narg_q, narg_d;
  logic [NargW-1:0] ei_q, ei_d;
  logic [7:0]       m0_q, m0_d;
  logic [7:0]       m1_q, m1_d;
  logic [16:0]      vals_q [ARG_SLOTS];

  // Classification results.
  logic                  ex_emit, ex_parse, ex_wr;
  tesp_pkg::event_kind_e ex_kind;
  logic [20:0]           ex_code;
  logic [1:0]            ex_slot;

  logic [7:0]  cur_byte;
  logic        cur_digit;
  logic [19:0] acc_next;

  assign cur_byte  = (p_q < clen_q) ? rdata_q : tesp_pkg::ChNul;
  assign cur_digit = (cur_byte >= tesp_pkg::ChZero) && (cur_byte <= tesp_pkg::ChNine);
  assign acc_next  = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                   + 20'(cur_byte - tesp_pkg::ChZero);

  // One input character: classification and escape state update.
  always_comb begin
    logic [7:0]        u8;
    logic              is_c1, is_ctl, is_term, done;
    logic [7:0]        sc;
    logic [SlenW:0]    ssum;
    logic [LenW-1:0]   clen_inc;
    u8        = cp_q[7:0];
    is_c1     = (cp_q >= 21'h80) && (cp_q <= 21'h9F);
    is_ctl    = (cp_q < 21'h20) || (cp_q == 21'h7F) || is_c1;
    is_term   = (cp_q == 21'(tesp_pkg::ChBel)) || (cp_q == 21'(tesp_pkg::ChCan))
             || (cp_q == 21'(tesp_pkg::ChSub)) || (cp_q == 21'(tesp_pkg::ChEsc)) || is_c1;
    done      = 1'b0;
    sc        = u8;
    ssum      = {1'b0, slen_q} + (SlenW + 1)'(bc_q);
    clen_inc  = clen_q;
    flags_d   = flags_q;
    six_d     = six_q;
    clen_d    = clen_q;
    slen_d    = slen_q;
    skind_d   = skind_q;
    dslot_d   = dslot_q;
    ex_emit   = 1'b0;
    ex_parse  = 1'b0;
    ex_wr     = 1'b0;
    ex_kind   = tesp_pkg::EV_PRINT;
    ex_code   = cp_q;
    ex_slot   = 2'd0;

    if (flags_q[tesp_pkg::FlStr]) begin
      if (is_term) begin
        flags_d[tesp_pkg::FlStart] = 1'b0;
        flags_d[tesp_pkg::FlStr]   = 1'b0;
        flags_d[tesp_pkg::FlDcs]   = 1'b0;
        if (six_q) begin
          six_d = 1'b0;
          done  = 1'b1;
        end else begin
          flags_d[tesp_pkg::FlStrEnd] = 1'b1;
        end
      end else begin
        done = 1'b1;
        if (!six_q) begin
          if (flags_q[tesp_pkg::FlDcs] && (slen_q == '0)
              && (cp_q == 21'(tesp_pkg::ChLowQ))) begin
            six_d = 1'b1;
          end
          ex_emit = 1'b1;
          if (ssum >= (SlenW + 1)'(STRING_LIMIT)) begin
            ex_kind = tesp_pkg::EV_STR_OVERFLOW;
          end else begin
            slen_d  = ssum[SlenW-1:0];
            ex_kind = tesp_pkg::EV_STR_BYTE;
          end
        end
      end
    end

    if (!done) begin
      if (is_ctl) begin
        ex_emit = 1'b1;
        ex_kind = tesp_pkg::EV_CONTROL;
        case (u8)
          tesp_pkg::ChBel: begin
            if (flags_d[tesp_pkg::FlStrEnd]) begin
              ex_kind = tesp_pkg::EV_STR_DISPATCH;
              ex_code = 21'(skind_q);
            end
            flags_d[tesp_pkg::FlStrEnd] = 1'b0;
            flags_d[tesp_pkg::FlStr]    = 1'b0;
          end
          tesp_pkg::ChEsc: begin
            clen_d = '0;
            flags_d[tesp_pkg::FlCsi]   = 1'b0;
            flags_d[tesp_pkg::FlAlt]   = 1'b0;
            flags_d[tesp_pkg::FlTest]  = 1'b0;
            flags_d[tesp_pkg::FlStart] = 1'b1;
          end
          tesp_pkg::ChCan, tesp_pkg::ChSub: begin
            clen_d = '0;
            flags_d[tesp_pkg::FlStrEnd] = 1'b0;
            flags_d[tesp_pkg::FlStr]    = 1'b0;
          end
          tesp_pkg::ChHt, tesp_pkg::ChBs, tesp_pkg::ChCr, tesp_pkg::ChLf,
          tesp_pkg::ChVt, tesp_pkg::ChFf, tesp_pkg::ChSo, tesp_pkg::ChSi,
          tesp_pkg::ChEnq, tesp_pkg::ChNul, tesp_pkg::ChXon, tesp_pkg::ChXoff,
          tesp_pkg::ChDel: begin
            // Plain control: the escape state is left as it is.
          end
          tesp_pkg::ChDcs, tesp_pkg::ChOsc, tesp_pkg::ChPm, tesp_pkg::ChApc: begin
            case (u8)
              tesp_pkg::ChDcs: sc = tesp_pkg::ChUpP;
              tesp_pkg::ChApc: sc = tesp_pkg::ChUnder;
              tesp_pkg::ChPm:  sc = tesp_pkg::ChCaret;
              default:         sc = tesp_pkg::ChRBrk;
            endcase
            slen_d = '0;
            if (sc == tesp_pkg::ChUpP) flags_d[tesp_pkg::FlDcs] = 1'b1;
            skind_d = sc;
            flags_d[tesp_pkg::FlStr] = 1'b1;
            ex_kind = tesp_pkg::EV_STR_START;
            ex_code = 21'(sc);
          end
          default: begin
            flags_d[tesp_pkg::FlStrEnd] = 1'b0;
            flags_d[tesp_pkg::FlStr]    = 1'b0;
          end
        endcase
      end else if (flags_d[tesp_pkg::FlStart]) begin
        if (flags_d[tesp_pkg::FlCsi]) begin
          if (clen_q < LenW'(CSI_BUF_BYTES)) begin
            ex_wr    = 1'b1;
            clen_inc = clen_q + 1'b1;
          end
          clen_d = clen_inc;
          if (((cp_q >= 21'(tesp_pkg::ChFinLo)) && (cp_q <= 21'(tesp_pkg::ChFinHi)))
              || (clen_inc >= LenW'(CSI_BUF_BYTES - 1))) begin
            flags_d  = '0;
            ex_parse = 1'b1;
          end
        end else if (flags_d[tesp_pkg::FlUtf8]) begin
          ex_emit = 1'b1;
          ex_kind = tesp_pkg::EV_UTF8_SELECT;
          flags_d = '0;
        end else if (flags_d[tesp_pkg::FlAlt]) begin
          ex_emit = 1'b1;
          ex_kind = tesp_pkg::EV_CHARSET;
          ex_slot = dslot_q;
          flags_d = '0;
        end else if (flags_d[tesp_pkg::FlTest]) begin
          ex_emit = 1'b1;
          ex_kind = tesp_pkg::EV_DEC_TEST;
          flags_d = '0;
        end else begin
          // ESC final byte.
          case (u8)
            tesp_pkg::ChLBrk: flags_d[tesp_pkg::FlCsi]  = 1'b1;
            tesp_pkg::ChHash: flags_d[tesp_pkg::FlTest] = 1'b1;
            tesp_pkg::ChPct:  flags_d[tesp_pkg::FlUtf8] = 1'b1;
            tesp_pkg::ChUpP, tesp_pkg::ChUnder, tesp_pkg::ChCaret,
            tesp_pkg::ChRBrk, tesp_pkg::ChLowK: begin
              slen_d = '0;
              if (u8 == tesp_pkg::ChUpP) flags_d[tesp_pkg::FlDcs] = 1'b1;
              skind_d = u8;
              flags_d[tesp_pkg::FlStr] = 1'b1;
              ex_emit = 1'b1;
              ex_kind = tesp_pkg::EV_STR_START;
              ex_code = 21'(u8);
            end
            tesp_pkg::ChLPar, tesp_pkg::ChRPar, tesp_pkg::ChStar, tesp_pkg::ChPlus: begin
              dslot_d = 2'(u8 - tesp_pkg::ChLPar);
              flags_d[tesp_pkg::FlAlt] = 1'b1;
            end
            tesp_pkg::ChBsl: begin
              ex_emit = 1'b1;
              if (flags_d[tesp_pkg::FlStrEnd]) begin
                ex_kind = tesp_pkg::EV_STR_DISPATCH;
                ex_code = 21'(skind_q);
              end else begin
                ex_kind = tesp_pkg::EV_ESC_FINAL;
                ex_code = 21'(u8);
              end
              flags_d = '0;
            end
            default: begin
              ex_emit = 1'b1;
              ex_kind = tesp_pkg::EV_ESC_FINAL;
              ex_code = 21'(u8);
              flags_d = '0;
            end
          endcase
        end
      end else begin
        ex_emit = 1'b1;
        ex_kind = tesp_pkg::EV_PRINT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      six_q   <= 1'b0;
      clen_q  <= '0;
      slen_q  <= '0;
      skind_q <= '0;
      dslot_q <= '0;
    end else if (cmd_i.exec) begin
      flags_q <= flags_d;
      six_q   <= six_d;
      clen_q  <= clen_d;
      slen_q  <= slen_d;
      skind_q <= skind_d;
      dslot_q <= dslot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cp_q <= code_point_i;
      bc_q <= byte_count_i;
    end
  end

  // CSI buffer: one write port, one registered read port that follows p.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && ex_wr) begin
      mem[clen_q[AddrW-1:0]] <= cp_q[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[p_d[AddrW-1:0]];
  end

  // Argument scan, one buffer byte at a time.
  always_comb begin
    p_d    = p_q;
    priv_d = priv_q;
    acc_d  = acc_q;
    over_d = over_q;
    narg_d = narg_q;
    ei_d   = ei_q;
    m0_d   = m0_q;
    m1_d   = m1_q;
    if (cmd_i.par_init) begin
      p_d    = '0;
      priv_d = 1'b0;
      acc_d  = '0;
      over_d = 1'b0;
      narg_d = '0;
      ei_d   = '0;
    end
    if (cmd_i.par_priv && (cur_byte == tesp_pkg::ChQmark)) begin
      priv_d = 1'b1;
      p_d    = LenW'(1);
    end
    if (cmd_i.par_dig) begin
      if (cur_digit) begin
        if (!over_q) begin
          acc_d = acc_next[15:0];
          if (acc_next > 20'hFFFF) over_d = 1'b1;
        end
        p_d = p_q + 1'b1;
      end else begin
        narg_d = narg_q + 1'b1;
        if ((cur_byte == tesp_pkg::ChSemi) && !sts_o.narg_last) begin
          p_d    = p_q + 1'b1;
          acc_d  = '0;
          over_d = 1'b0;
        end
      end
    end
    if (cmd_i.par_m0) begin
      m0_d = cur_byte;
      p_d  = p_q + 1'b1;
    end
    if (cmd_i.par_m1) begin
      m1_d = cur_byte;
    end
    if (cmd_i.emit_arg) begin
      ei_d = ei_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    priv_q <= priv_d;
    acc_q  <= acc_d;
    over_q <= over_d;
    narg_q <= narg_d;
    ei_q   <= ei_d;
    m0_q   <= m0_d;
    m1_q   <= m1_d;
    if (cmd_i.par_dig && !cur_digit) begin
      vals_q[narg_q[IdxW-1:0]] <= over_q ? 17'h1FFFF : {1'b0, acc_q};
    end
  end

  // Output register.
  logic out_load;
  assign out_load = (cmd_i.exec && ex_emit) || cmd_i.emit_arg || cmd_i.emit_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && ex_emit) begin
      event_kind_o   <= ex_kind;
      code_o         <= ex_code;
      arg_index_o    <= '0;
      arg_value_o    <= '0;
      private_mark_o <= 1'b0;
      second_mode_o  <= '0;
      charset_slot_o <= ex_slot;
      last_o         <= 1'b1;
    end else if (cmd_i.emit_arg) begin
      event_kind_o   <= tesp_pkg::EV_CSI_ARG;
      code_o         <= 21'(m0_q);
      arg_index_o    <= 4'(ei_q);
      arg_value_o    <= vals_q[ei_q[IdxW-1:0]];
      private_mark_o <= priv_q;
      second_mode_o  <= m1_q;
      charset_slot_o <= '0;
      last_o         <= 1'b0;
    end else if (cmd_i.emit_fin) begin
      event_kind_o   <= tesp_pkg::EV_CSI_FINAL;
      code_o         <= 21'(m0_q);
      arg_index_o    <= '0;
      arg_value_o    <= '0;
      private_mark_o <= priv_q;
      second_mode_o  <= m1_q;
      charset_slot_o <= '0;
      last_o         <= 1'b1;
    end
  end

  assign sts_o.out_free    = !out_valid_o || out_ready_i;
  assign sts_o.start_parse = ex_parse;
  assign sts_o.p_lt_len    = p_q < clen_q;
  assign sts_o.byte_digit  = cur_digit;
  assign sts_o.byte_semi   = cur_byte == tesp_pkg::ChSemi;
  assign sts_o.narg_last   = narg_q == NargW'(ARG_SLOTS - 1);
  assign sts_o.ei_lt_narg  = ei_q < narg_q;

endmodule

// File: hw/rtl/terminal_escape_sequence_parser.sv
// ----------------------------------------------------------------------------
// Terminal escape sequence parser
// Classifies decoded characters and reports escape, CSI and string events.
// ----------------------------------------------------------------------------
// A request's single event, if any, is loaded into the output register from the
// execute state once that register is free. A CSI final byte then starts the
// argument scan: private mark check, digit scan, mode bytes, then the events.
// No new request is taken until the previous one, with any CSI scan, is done;
// the scan reads buffer bytes one at a time through the single buffer read port.
// Reset clears the escape state, lengths and handshakes; the CSI buffer is not
// cleared, since only entries written in the current sequence are ever read.
module terminal_escape_sequence_parser #(
  parameter int unsigned ARG_SLOTS     = tesp_pkg::ArgSlotsDef,
  parameter int unsigned CSI_BUF_BYTES = tesp_pkg::CsiBufBytesDef,
  parameter int unsigned STRING_LIMIT  = tesp_pkg::StringLimitDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [20:0]        code_point_i,
  input  logic [2:0]         byte_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         event_kind_o,
  output logic [20:0]        code_o,
  output logic [3:0]         arg_index_o,
  output logic signed [16:0] arg_value_o,
  output logic               private_mark_o,
  output logic [7:0]         second_mode_o,
  output logic [1:0]         charset_slot_o,
  output logic               last_o
);

  // The controller only steps the datapath; all escape state, the CSI buffer
  // and the output register live in the datapath.
  tesp_pkg::cmd_t cmd;
  tesp_pkg::sts_t sts;

  tesp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The item register in the datapath lets a new request be taken while the
  // previous event still waits in the output register.
  tesp_dpath #(
    .ARG_SLOTS     (ARG_SLOTS),
    .CSI_BUF_BYTES (CSI_BUF_BYTES),
    .STRING_LIMIT  (STRING_LIMIT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .code_point_i   (code_point_i),
    .byte_count_i   (byte_count_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .code_o         (code_o),
    .arg_index_o    (arg_index_o),
    .arg_value_o    (arg_value_o),
    .private_mark_o (private_mark_o),
    .second_mode_o  (second_mode_o),
    .charset_slot_o (charset_slot_o),
    .last_o         (last_o)
  );

endmodule

// File: hw/rtl/tesp_check.sv
// ----------------------------------------------------------------------------
// Parser port checker
// Watches the result channel of the parser for valid hold and event field consistency.
// ----------------------------------------------------------------------------
module tesp_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  event_kind_o,
  input logic [3:0]  arg_index_o,
  input logic [16:0] arg_value_o,
  input logic [1:0]  charset_slot_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped before it was taken");

  a_arg_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == tesp_pkg::EV_CSI_ARG) |-> !last_o)
    else $error("CSI argument marked as last event");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == tesp_pkg::EV_CSI_FINAL)
      |-> last_o && (arg_index_o == 4'd0) && (arg_value_o == 17'd0))
    else $error("CSI final event malformed");

  a_slot_only_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != tesp_pkg::EV_CHARSET) |-> charset_slot_o == 2'd0)
    else $error("charset slot set on a non-charset event");

endmodule

bind terminal_escape_sequence_parser tesp_check u_tesp_check (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .event_kind_o   (event_kind_o),
  .arg_index_o    (arg_index_o),
  .arg_value_o    (arg_value_o),
  .charset_slot_o (charset_slot_o),
  .last_o         (last_o)
);
